/* src/srh_pkg.sv */
// Shared types, codes and constants for the sorted range histogram.
`default_nettype none

package srh_pkg;

    // Fixed field widths
    localparam int IDX_W   = 10;
    localparam int PTR_W   = 11;
    localparam int CNT_W   = 31;
    localparam int VAL_W   = 32;
    localparam int OP_W    = 2;
    localparam int STS_W   = 2;

    // Default table depth
    localparam int MAX_RANGES_DEF = 1024;

    // Saturation limit of a range count
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_COUNT = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // Status codes
    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_PAST  = 2'd1;
    localparam logic [STS_W-1:0] STS_BELOW = 2'd2;
    localparam logic [STS_W-1:0] STS_INDEX = 2'd3;

    // One table entry: bounds plus count
    typedef struct packed {
        logic signed [VAL_W-1:0] lower;
        logic signed [VAL_W-1:0] upper;
        logic [CNT_W-1:0]        count;
    } t_entry;

    // One accepted item
    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] lower;
        logic signed [VAL_W-1:0] upper;
        logic signed [VAL_W-1:0] sample;
    } t_item;

    // One result item
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] hit;
        logic [STS_W-1:0] status;
    } t_result;

    // What the evaluator decides for one cycle of work
    typedef struct packed {
        logic    advance;   // move scan past current range, read the next
        logic    finish;    // result is ready
        logic    wr_en;     // write the entry back
        logic    rewind;    // clear the scan pointer
        t_entry  wr_entry;
        t_result res;
    } t_decision;

endpackage

`default_nettype wire

/* src/srh_eval.sv */
// Per-cycle evaluation of one table entry against the item in flight.
`default_nettype none

module srh_eval (
    input  var srh_pkg::t_item     i_item,
    input  var srh_pkg::t_entry    i_entry,
    input  var logic [10:0]        i_ptr,
    input  var logic [10:0]        i_active,
    output var srh_pkg::t_decision o_dec
);
    import srh_pkg::*;

    logic             idx_bad;
    logic             ptr_end;
    logic [CNT_W-1:0] cnt_inc;

    assign idx_bad = ({1'b0, i_item.idx} >= i_active);
    assign ptr_end = (i_ptr >= i_active);
    assign cnt_inc = (i_entry.count == COUNT_MAX) ? i_entry.count
                                                  : i_entry.count + 1'b1;

    always_comb begin
        o_dec            = '0;
        o_dec.wr_entry   = i_entry;
        unique case (i_item.op)
            OP_LOAD: begin
                o_dec.finish   = 1'b1;
                o_dec.res.hit  = i_item.idx;
                if (idx_bad) begin
                    o_dec.res.status = STS_INDEX;
                end else begin
                    o_dec.wr_en          = 1'b1;
                    o_dec.rewind         = 1'b1;
                    o_dec.wr_entry.lower = i_item.lower;
                    o_dec.wr_entry.upper = i_item.upper;
                    o_dec.wr_entry.count = '0;
                    o_dec.res.status     = STS_OK;
                end
            end
            OP_COUNT: begin
                if (ptr_end) begin
                    // ran off the last range
                    o_dec.finish     = 1'b1;
                    o_dec.res.status = STS_PAST;
                end else if (i_entry.upper <= i_item.sample) begin
                    o_dec.advance = 1'b1;
                end else if (i_item.sample < i_entry.lower) begin
                    // gap or unsorted sample: report, do not count
                    o_dec.finish     = 1'b1;
                    o_dec.res.count  = i_entry.count;
                    o_dec.res.hit    = i_ptr[IDX_W-1:0];
                    o_dec.res.status = STS_BELOW;
                end else begin
                    o_dec.finish         = 1'b1;
                    o_dec.wr_en          = 1'b1;
                    o_dec.wr_entry.count = cnt_inc;
                    o_dec.res.count      = cnt_inc;
                    o_dec.res.hit        = i_ptr[IDX_W-1:0];
                    o_dec.res.status     = STS_OK;
                end
            end
            OP_READ: begin
                o_dec.finish  = 1'b1;
                o_dec.res.hit = i_item.idx;
                if (idx_bad) begin
                    o_dec.res.status = STS_INDEX;
                end else begin
                    o_dec.res.count  = i_entry.count;
                    o_dec.res.status = STS_OK;
                end
            end
            default: begin
                o_dec.finish = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/sorted_range_histogram.sv */
// Top level: counts an ascending sample stream into a table of ranges.
//
//  Channel  Signals                                   Direction
//  -------  ----------------------------------------  ---------
//  in       i_in_valid / o_in_stall, operation..sample  into block
//  out      o_out_valid / i_out_stall, count..status    out of block
//  cfg      i_cfg_valid / o_cfg_ready, i_cfg_data       into block
//
// An item is accepted with a table read, then evaluated and written back; the
// scan reads one further range for every range the scan pointer steps past,
// through the single read port of the range table.
// Reset clears control state only; table contents are undefined until loaded.
// A result waits in the output register; when it is stalled, the next item
// holds in its evaluate cycle until the register frees.
`default_nettype none

module sorted_range_histogram #(
    parameter int MAX_RANGES = srh_pkg::MAX_RANGES_DEF
) (
    input  var logic                         i_clk,
    input  var logic                         i_rst_n,

    input  var logic                         i_in_valid,
    output var logic                         o_in_stall,
    input  var logic [srh_pkg::OP_W-1:0]     i_operation,
    input  var logic [srh_pkg::IDX_W-1:0]    i_range_index,
    input  var logic signed [srh_pkg::VAL_W-1:0] i_lower_bound,
    input  var logic signed [srh_pkg::VAL_W-1:0] i_upper_bound,
    input  var logic signed [srh_pkg::VAL_W-1:0] i_sample,

    output var logic                         o_out_valid,
    input  var logic                         i_out_stall,
    output var logic [srh_pkg::CNT_W-1:0]    o_count_out,
    output var logic [srh_pkg::IDX_W-1:0]    o_hit_range,
    output var logic [srh_pkg::STS_W-1:0]    o_status,

    input  var logic                         i_cfg_valid,
    output var logic                         o_cfg_ready,
    input  var logic [srh_pkg::PTR_W-1:0]    i_cfg_data
);
    import srh_pkg::*;

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    // Sequencer states
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    logic             r_state, n_state;
    logic [PTR_W-1:0] r_ranges;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic [PTR_W-1:0] active_cnt;
    logic [PTR_W-1:0] ptr_clamp;
    t_item            r_item;
    t_entry           r_mem [MAX_RANGES];
    t_entry           r_rd_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic             in_fire;
    logic             out_free;
    logic             done_fire;
    t_decision        dec;
    logic             r_out_valid;
    t_result          r_out;

    // Effective number of ranges
    always_comb begin
        if (32'(r_ranges) > MAX_RANGES) begin
            active_cnt = PTR_W'(MAX_RANGES);
        end else begin
            active_cnt = r_ranges;
        end
    end

    assign ptr_clamp = (r_ptr > active_cnt) ? active_cnt : r_ptr;

    // Handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign done_fire   = (r_state == S_EVAL) && dec.finish && out_free;

    // Entry evaluation
    srh_eval u_eval (
        .i_item   (r_item),
        .i_entry  (r_rd_data),
        .i_ptr    (r_ptr),
        .i_active (active_cnt),
        .o_dec    (dec)
    );

    // Table port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = AW'(ptr_clamp);
        n_ptr   = r_ptr;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    rd_en   = 1'b1;
                    n_ptr   = ptr_clamp;
                    n_state = S_EVAL;
                    if (i_operation == OP_READ) begin
                        rd_addr = AW'(i_range_index);
                    end
                end
            end
            S_EVAL: begin
                if (dec.advance) begin
                    rd_en   = 1'b1;
                    n_ptr   = r_ptr + 1'b1;
                    rd_addr = AW'(n_ptr);
                end else if (done_fire) begin
                    n_state = S_IDLE;
                    if (dec.rewind) begin
                        n_ptr = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign wr_en   = done_fire && dec.wr_en;
    assign wr_addr = (r_item.op == OP_LOAD) ? AW'(r_item.idx) : AW'(r_ptr);

    // Range table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= dec.wr_entry;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_ranges    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_out_valid <= done_fire || (r_out_valid && i_out_stall);
            if (i_cfg_valid && o_cfg_ready) begin
                r_ranges <= i_cfg_data;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.op     <= i_operation;
            r_item.idx    <= i_range_index;
            r_item.lower  <= i_lower_bound;
            r_item.upper  <= i_upper_bound;
            r_item.sample <= i_sample;
        end
        if (done_fire) begin
            r_out <= dec.res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_count_out = r_out.count;
    assign o_hit_range = r_out.hit;
    assign o_status    = r_out.status;

    // Checks
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_EVAL))
        else $error("accepted item did not enter evaluation");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_ptr <= active_cnt))
        else $error("scan pointer beyond active ranges");

    a_write_when: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ((r_state == S_EVAL) && out_free && !dec.advance))
        else $error("table write outside a finishing cycle");

    a_past_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STS_PAST)) |->
            ((o_count_out == '0) && (o_hit_range == '0)))
        else $error("past-last result carries nonzero fields");

endmodule

`default_nettype wire

/* tb/sv/tb_sorted_range_histogram.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the sorted range histogram: directed and random items.
module tb_sorted_range_histogram;
    import srh_pkg::*;

    // table depth below the register range so the clamp to the depth is reached quickly
    localparam int NR           = 64;
    localparam int IDLE_LIMIT   = 8000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 420;
    localparam logic signed [VAL_W-1:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] V_MAX = 32'sh7fff_ffff;

    // item waiting to be sent; drain holds it back until all results are in
    typedef struct {
        t_item it;
        bit    drain;
    } t_pending;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_in_valid    = 1'b0;
    logic                    o_in_stall;
    logic [OP_W-1:0]         i_operation   = '0;
    logic [IDX_W-1:0]        i_range_index = '0;
    logic signed [VAL_W-1:0] i_lower_bound = '0;
    logic signed [VAL_W-1:0] i_upper_bound = '0;
    logic signed [VAL_W-1:0] i_sample      = '0;
    logic                    o_out_valid;
    logic                    i_out_stall   = 1'b0;
    logic [CNT_W-1:0]        o_count_out;
    logic [IDX_W-1:0]        o_hit_range;
    logic [STS_W-1:0]        o_status;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [PTR_W-1:0]        i_cfg_data    = '0;

    sorted_range_histogram #(.MAX_RANGES(NR)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_range_index (i_range_index),
        .i_lower_bound (i_lower_bound),
        .i_upper_bound (i_upper_bound),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_count_out   (o_count_out),
        .o_hit_range   (o_hit_range),
        .o_status      (o_status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state: range table, scan pointer, register copy
    logic signed [VAL_W-1:0] lo_tab    [NR];
    logic signed [VAL_W-1:0] hi_tab    [NR];
    logic [CNT_W-1:0]        tally_tab [NR];
    int unsigned             scan_at       = 0;
    logic [PTR_W-1:0]        range_setting = '0;

    // generator's view of the table it has loaded
    int          plan_lo      [NR];
    int          plan_hi      [NR];
    bit          plan_written [NR];
    int unsigned plan_ranges = 0;

    t_pending    pending_items[$];
    t_result     expected_tallies[$];

    t_pending    offered;
    bit          offering      = 1'b0;
    bit          send_burst    = 1'b0;
    bit          recv_burst    = 1'b0;
    int          send_gap      = 0;
    int          stall_left    = 0;
    int          failures      = 0;
    int          items_accepted = 0;
    int          results_seen  = 0;
    int          cfg_writes    = 0;
    int          stream_items  = 0;
    int          quiet_cycles  = 0;
    int          status_seen [4];

    // one accepted item: update the table copy and return the result it should give
    function automatic t_result histogram_predict(t_item it);
        t_result     r;
        int unsigned n;
        int unsigned p;
        n = (range_setting > NR) ? NR : range_setting;
        r = '0;
        case (it.op)
            OP_LOAD: begin
                r.hit = it.idx;
                if (it.idx >= n) begin
                    r.status = STS_INDEX;
                end else begin
                    lo_tab[it.idx]    = it.lower;
                    hi_tab[it.idx]    = it.upper;
                    tally_tab[it.idx] = '0;
                    scan_at           = 0;
                end
            end
            OP_COUNT: begin
                // clip a pointer left over from a larger setting, then skip ranges
                p = (scan_at > n) ? n : scan_at;
                while (p < n && $signed(hi_tab[p]) <= $signed(it.sample)) p++;
                scan_at = p;
                if (p >= n) begin
                    r.status = STS_PAST;
                end else if ($signed(it.sample) < $signed(lo_tab[p])) begin
                    r.count  = tally_tab[p];
                    r.hit    = p[IDX_W-1:0];
                    r.status = STS_BELOW;
                end else begin
                    if (tally_tab[p] != COUNT_MAX) tally_tab[p] = tally_tab[p] + 1'b1;
                    r.count = tally_tab[p];
                    r.hit   = p[IDX_W-1:0];
                end
            end
            OP_READ: begin
                r.hit = it.idx;
                if (it.idx >= n) begin
                    r.status = STS_INDEX;
                end else begin
                    r.count = tally_tab[it.idx];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // queue one item and track loads that land in the table
    task automatic push_item(logic [OP_W-1:0] op, int unsigned idx, int lo, int hi, int smp,
                             bit drain = 1'b0);
        t_pending e;
        e.it.op     = op;
        e.it.idx    = idx[IDX_W-1:0];
        e.it.lower  = lo;
        e.it.upper  = hi;
        e.it.sample = smp;
        e.drain     = drain;
        if (op == OP_LOAD && idx < plan_ranges) begin
            plan_lo[idx]      = lo;
            plan_hi[idx]      = hi;
            plan_written[idx] = 1'b1;
        end
        pending_items.push_back(e);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || offering || expected_tallies.size() != 0)
            @(posedge i_clk);
    endtask

    // register write, only with the block drained
    task automatic write_ranges(int unsigned setting);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= PTR_W'(setting);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        range_setting = PTR_W'(setting);
        plan_ranges   = (setting > NR) ? NR : setting;
        cfg_writes++;
    endtask

    // fresh ascending table over n ranges, with gaps, adjacent, empty and inverted ranges
    task automatic build_table(int unsigned n);
        int cut_points[$];
        int lo;
        int hi;
        int swap;
        bit adjacent;
        repeat (2 * n) cut_points.push_back($urandom);
        cut_points.sort();
        adjacent = 1'($urandom_range(0, 1));
        for (int k = 0; k < n; k++) begin
            lo = adjacent ? cut_points[k] : cut_points[2 * k];
            hi = adjacent ? cut_points[k + 1] : cut_points[2 * k + 1];
            case ($urandom_range(0, 9))
                0: hi = lo;
                1: begin
                    swap = lo;
                    lo   = hi;
                    hi   = swap;
                end
                default: ;
            endcase
            push_item(OP_LOAD, k, lo, hi, $urandom);
        end
    endtask

    // ascending sample stream aimed at the loaded ranges, with some noise mixed in
    task automatic sample_run(int unsigned n, int m);
        int          picks[$];
        int unsigned k;
        longint      span;
        int          v;
        repeat (m) begin
            k    = (n > 0) ? $urandom_range(0, n - 1) : 0;
            span = longint'(plan_hi[k]) - longint'(plan_lo[k]);
            case ($urandom_range(0, 9))
                0: v = plan_lo[k];
                1: v = plan_hi[k];
                2, 3: v = $urandom;
                default: begin
                    if (span > 0) v = int'(longint'(plan_lo[k]) + longint'($urandom) % span);
                    else v = $urandom;
                end
            endcase
            if (n == 0) v = $urandom;
            picks.push_back(v);
        end
        picks.sort();
        foreach (picks[j]) begin
            if ($urandom_range(0, 7) == 0) begin
                k = (n > 0) ? $urandom_range(0, n - 1) : 0;
                case ($urandom_range(0, 5))
                    0: if (n > 0) push_item(OP_READ, k, $urandom, $urandom, $urandom);
                    1: push_item(OP_READ, $urandom_range(0, NR - 1), $urandom, $urandom, $urandom);
                    2: push_item(OP_NONE, $urandom_range(0, NR - 1), $urandom, $urandom, $urandom);
                    3: push_item(OP_COUNT, $urandom_range(0, NR - 1), $urandom, $urandom, $urandom);
                    4: if (n > 0) push_item(OP_LOAD, k, plan_lo[k], plan_hi[k], $urandom);
                    default: push_item(OP_LOAD, $urandom_range(0, NR - 1), $urandom, $urandom,
                                       $urandom);
                endcase
                stream_items++;
            end
            push_item(OP_COUNT, $urandom_range(0, NR - 1), $urandom, $urandom, picks[j],
                      j == m / 2);
            stream_items++;
        end
    endtask

    // input driver: random gap per item, bursts with no gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_tallies.push_back(histogram_predict(offered.it));
                items_accepted++;
                offering = 1'b0;
                send_gap = send_burst ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() > 0 &&
                             !(pending_items[0].drain && expected_tallies.size() > 0)) begin
                    offered  = pending_items.pop_front();
                    offering = 1'b1;
                    i_operation   <= offered.it.op;
                    i_range_index <= offered.it.idx;
                    i_lower_bound <= offered.it.lower;
                    i_upper_bound <= offered.it.upper;
                    i_sample      <= offered.it.sample;
                end
            end
            i_in_valid <= offering;
        end
    end

    // result monitor and output stall; two long hold-offs to back the block up
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                status_seen[o_status]++;
                if (expected_tallies.size() == 0) begin
                    $error("unexpected result: count_out %0d hit_range %0d status %0d",
                           o_count_out, o_hit_range, o_status);
                    failures++;
                end else begin
                    want = expected_tallies.pop_front();
                    if (o_count_out !== want.count) begin
                        $error("count_out: expected %0d, got %0d", want.count, o_count_out);
                        failures++;
                    end
                    if (o_hit_range !== want.hit) begin
                        $error("hit_range: expected %0d, got %0d", want.hit, o_hit_range);
                        failures++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        failures++;
                    end
                end
                results_seen++;
                stall_left = recv_burst ? 0 : $urandom_range(0, 7);
                if (results_seen == 40 || results_seen == 400) stall_left = LONG_HOLD;
                if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_out_stall <= (stall_left > 0);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d cycles without progress", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        int unsigned settings[$];
        bit          rebuild;
        int unsigned n;
        settings = '{3, 0, 2047, 1024, 1, 12, 40, 2, 64, 5};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no ranges in use after reset
        push_item(OP_COUNT, 0, $urandom, $urandom, V_MIN);
        push_item(OP_READ, 0, $urandom, $urandom, $urandom);

        // five ranges: full-span bounds, empty, inverted, gap before the last
        write_ranges(5);
        push_item(OP_READ, NR - 1, $urandom, $urandom, $urandom);
        push_item(OP_LOAD, NR - 1, 0, 0, $urandom);
        push_item(OP_LOAD, 0, V_MIN, -1000, $urandom);
        push_item(OP_LOAD, 1, -1000, -1000, $urandom);
        push_item(OP_LOAD, 2, -500, -600, $urandom);
        push_item(OP_LOAD, 3, 0, 100, $urandom);
        push_item(OP_LOAD, 4, 200, V_MAX, $urandom);
        push_item(OP_COUNT, 0, $urandom, $urandom, V_MIN);
        push_item(OP_COUNT, 0, $urandom, $urandom, -1001);
        push_item(OP_COUNT, 0, $urandom, $urandom, -1000);
        push_item(OP_COUNT, 0, $urandom, $urandom, -550);
        push_item(OP_COUNT, 0, $urandom, $urandom, 0);
        push_item(OP_COUNT, 0, $urandom, $urandom, 99);
        push_item(OP_COUNT, 0, $urandom, $urandom, -5);
        push_item(OP_COUNT, 0, $urandom, $urandom, 150);
        push_item(OP_COUNT, 0, $urandom, $urandom, V_MAX);
        push_item(OP_READ, 3, $urandom, $urandom, $urandom);
        push_item(OP_NONE, NR - 1, -1, -1, -1);
        push_item(OP_LOAD, 3, 0, 100, $urandom);
        push_item(OP_COUNT, 0, $urandom, $urandom, 5);

        // shrink below the scan pointer
        write_ranges(2);
        push_item(OP_COUNT, 0, $urandom, $urandom, 5);
        push_item(OP_READ, 3, $urandom, $urandom, $urandom);

        // random phases, each under its own register setting
        while (stream_items < RANDOM_ITEMS) begin
            if (settings.size() > 0) n = settings.pop_front();
            else n = $urandom_range(1, 32);
            write_ranges(n);
            rebuild = (plan_ranges <= 64) && ($urandom_range(0, 2) != 0);
            for (int k = 0; k < plan_ranges; k++) begin
                if (!plan_written[k]) rebuild = 1'b1;
            end
            if (plan_ranges > 0 && rebuild) build_table(plan_ranges);
            sample_run(plan_ranges, (plan_ranges > 64) ? 80 : $urandom_range(30, 70));
        end

        wait_idle();
        repeat (16) @(posedge i_clk);
        $display("Checked %0d results from %0d items under %0d register settings",
                 results_seen, items_accepted, cfg_writes);
        $display("Statuses: ok %0d, past last %0d, below lower %0d, index out of use %0d",
                 status_seen[STS_OK], status_seen[STS_PAST], status_seen[STS_BELOW],
                 status_seen[STS_INDEX]);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
src/srh_pkg.sv
src/srh_eval.sv
src/sorted_range_histogram.sv
tb/sv/tb_sorted_range_histogram.sv
